FILE: rtl/klg88_pkg.sv
// shared types and constants for the klglott88 glottal source core
// no dependencies; used by klg88_regs, klg88_ctrl, klg88_dp and the top level
package klg88_pkg;

  // register field widths
  localparam int PER_W  = 13;
  localparam int LIN_W  = 47;
  localparam int OFS_W  = 48;
  localparam int OUT_W  = 16;
  localparam int ACC_W  = 32;

  // apb port sizes
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  // fixed point: 40 fraction bits down to q1.15, saturation limit of the exact sample
  localparam int FRAC_SHIFT = 25;
  localparam int SAT_BIT    = 62;

  // register reset values
  localparam logic [PER_W-1:0] PERIOD_RST = 13'd160;
  localparam logic [PER_W-1:0] OPEN_RST   = 13'd136;

  // register indexes
  typedef enum logic [2:0] {
    REG_PERIOD_LEN = 3'd0,
    REG_OPEN_LEN   = 3'd1,
    REG_LIN_COEF   = 3'd2,
    REG_QUAD_COEF  = 3'd3,
    REG_OFFSET     = 3'd4
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [PER_W-1:0]        period_len;
    logic [PER_W-1:0]        open_len;
    logic [LIN_W-1:0]        lin_coef;
    logic [LIN_W-1:0]        quad_coef;
    logic signed [OFS_W-1:0] offset;
  } cfg_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic diff;
    logic deriv;
    logic emit;
  } cmd_t;

endpackage

FILE: rtl/klg88_glottal_source_core.sv
// channel  | signals                                      | direction
// ---------+----------------------------------------------+----------
// tick in  | in_valid, in_ready, restart                  | in
// sample   | out_valid, out_ready, flow_derivative, flow,  | out
//          | open_phase                                   |
// config   | psel, penable, pwrite, paddr, pwdata, prdata | apb
//
// steps of an item from accept to result: accept, two multiply steps
// (linear and quadratic products, then the second factor of n), difference,
// offset/shift/clamp, and the flow sum update into the output register.
// a new item is accepted once the previous one is in the output register,
// even while that result still waits; a stalled output holds the last step.
// rst is synchronous; it resets phase counter, flow sum and config registers.
//
// top level of the glottal source; depends on klg88_pkg, klg88_regs,
// klg88_ctrl and klg88_dp
module klglott88_glottal_source_core #(
  parameter int PERIOD_MAX = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [klg88_pkg::OUT_W-1:0]  flow_derivative,
  output logic signed [klg88_pkg::OUT_W-1:0]  flow,
  output logic                                open_phase,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [klg88_pkg::ADDR_W-1:0]        paddr,
  input  logic [klg88_pkg::DATA_W-1:0]        pwdata,
  output logic [klg88_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  klg88_pkg::cfg_t cfg;
  klg88_pkg::cmd_t cmd;

  assign pready = 1'b1;

  // configuration registers
  klg88_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer
  klg88_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and state
  klg88_dp #(
    .PERIOD_MAX (PERIOD_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .restart         (restart),
    .flow_derivative (flow_derivative),
    .flow            (flow),
    .open_phase      (open_phase)
  );

`ifndef SYNTHESIS
  // one item in flight: an accept closes the input until the result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a closed phase sample carries no derivative
  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !open_phase) |-> (flow_derivative == '0))
    else $error("nonzero derivative outside the open phase");

  // a fresh result only follows work that held the input closed
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item being worked");
`endif

endmodule

FILE: rtl/klg88_regs.sv
// apb configuration registers of the glottal source
// depends on klg88_pkg
module klg88_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [klg88_pkg::ADDR_W-1:0]  paddr,
  input  logic [klg88_pkg::DATA_W-1:0]  pwdata,
  output logic [klg88_pkg::DATA_W-1:0]  prdata,
  output klg88_pkg::cfg_t               cfg
);

  klg88_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx   = klg88_pkg::reg_idx_t'(paddr[klg88_pkg::ADDR_W-1:3]);
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_len <= klg88_pkg::PERIOD_RST;
      cfg.open_len   <= klg88_pkg::OPEN_RST;
      cfg.lin_coef   <= '0;
      cfg.quad_coef  <= '0;
      cfg.offset     <= '0;
    end else if (wr_en) begin
      case (idx)
        klg88_pkg::REG_PERIOD_LEN: cfg.period_len <= pwdata[klg88_pkg::PER_W-1:0];
        klg88_pkg::REG_OPEN_LEN:   cfg.open_len   <= pwdata[klg88_pkg::PER_W-1:0];
        klg88_pkg::REG_LIN_COEF:   cfg.lin_coef   <= pwdata[klg88_pkg::LIN_W-1:0];
        klg88_pkg::REG_QUAD_COEF:  cfg.quad_coef  <= pwdata[klg88_pkg::LIN_W-1:0];
        klg88_pkg::REG_OFFSET:     cfg.offset     <= $signed(pwdata[klg88_pkg::OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      klg88_pkg::REG_PERIOD_LEN: prdata = klg88_pkg::DATA_W'(cfg.period_len);
      klg88_pkg::REG_OPEN_LEN:   prdata = klg88_pkg::DATA_W'(cfg.open_len);
      klg88_pkg::REG_LIN_COEF:   prdata = klg88_pkg::DATA_W'(cfg.lin_coef);
      klg88_pkg::REG_QUAD_COEF:  prdata = klg88_pkg::DATA_W'(cfg.quad_coef);
      klg88_pkg::REG_OFFSET:     prdata = klg88_pkg::DATA_W'($unsigned(cfg.offset));
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/klg88_ctrl.sv
// sequencing state machine of the glottal source
// depends on klg88_pkg; drives the commands of klg88_dp
module klg88_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output klg88_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIFF,
    ST_DERIV,
    ST_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // one command per state
  always_comb begin
    cmd       = '0;
    cmd.load  = in_valid && (state == ST_IDLE);
    cmd.mul1  = (state == ST_MUL1);
    cmd.mul2  = (state == ST_MUL2);
    cmd.diff  = (state == ST_DIFF);
    cmd.deriv = (state == ST_DERIV);
    cmd.emit  = (state == ST_EMIT) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:  if (in_valid) state <= ST_MUL1;
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_DIFF;
        ST_DIFF:  state <= ST_DERIV;
        ST_DERIV: state <= ST_EMIT;
        ST_EMIT:  if (out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/klg88_dp.sv
// datapath of the glottal source: phase counter, multiplies, saturation, flow sum
// depends on klg88_pkg; sequenced by klg88_ctrl
module klg88_dp #(
  parameter int PERIOD_MAX = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  klg88_pkg::cmd_t                     cmd,
  input  klg88_pkg::cfg_t                     cfg,
  input  logic                                restart,
  output logic signed [klg88_pkg::OUT_W-1:0]  flow_derivative,
  output logic signed [klg88_pkg::OUT_W-1:0]  flow,
  output logic                                open_phase
);

  localparam int CW     = $clog2(PERIOD_MAX);
  localparam int PROD_W = klg88_pkg::LIN_W + CW;
  localparam int NEG_W  = klg88_pkg::LIN_W + 2 * CW;
  localparam int DIFF_W = (NEG_W + 2 > 64) ? NEG_W + 2 : 64;
  localparam int SHR_W  = 64 - klg88_pkg::FRAC_SHIFT;
  localparam int OUT_W  = klg88_pkg::OUT_W;
  localparam int ACC_W  = klg88_pkg::ACC_W;

  logic [CW-1:0]              phase_count;
  logic [CW-1:0]              n_reg;
  logic                       open_reg;
  logic [PROD_W-1:0]          pos;
  logic [PROD_W-1:0]          q1;
  logic [NEG_W-1:0]           neg;
  logic signed [DIFF_W-1:0]   dval;
  logic signed [OUT_W-1:0]    d_reg;
  logic signed [ACC_W-1:0]    flow_sum;

  logic [CW-1:0]              n_cur;
  logic [CW:0]                n_inc;
  logic                       wrap;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [63:0]         v;
  logic signed [SHR_W-1:0]    v_shr;
  logic signed [OUT_W-1:0]    d_next;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W-1:0]    flow_sum_next;

  // counter value for this item and its successor
  always_comb begin
    n_cur = restart ? '0 : phase_count;
    n_inc = {1'b0, n_cur} + 1'b1;
    wrap  = (32'(n_inc) >= 32'(cfg.period_len)) || (32'(n_inc) == 32'(PERIOD_MAX));
  end

  // saturation flags of the exact sample, then offset, floor shift and q1.15 clamp
  always_comb begin
    sat_hi = !dval[DIFF_W-1] && (|dval[DIFF_W-2:klg88_pkg::SAT_BIT]);
    sat_lo = dval[DIFF_W-1] &&
             (!(&dval[DIFF_W-2:klg88_pkg::SAT_BIT]) || (dval[klg88_pkg::SAT_BIT-1:0] == '0));
    v      = $signed(dval[63:0]) - 64'(cfg.offset);
    v_shr  = v[63:klg88_pkg::FRAC_SHIFT];
    if (sat_hi) begin
      d_next = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sat_lo) begin
      d_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else if (v_shr > SHR_W'($signed({1'b0, {(OUT_W-1){1'b1}}}))) begin
      d_next = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v_shr < SHR_W'($signed({1'b1, {(OUT_W-1){1'b0}}}))) begin
      d_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      d_next = v_shr[OUT_W-1:0];
    end
  end

  // running flow sum with 32 bit saturation
  always_comb begin
    acc_sum = (ACC_W+1)'(flow_sum) + (ACC_W+1)'(d_reg);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      flow_sum_next = {acc_sum[ACC_W], {(ACC_W-1){!acc_sum[ACC_W]}}};
    end else begin
      flow_sum_next = acc_sum[ACC_W-1:0];
    end
  end

  // phase counter and flow sum
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      flow_sum    <= '0;
    end else begin
      if (cmd.load) begin
        phase_count <= wrap ? '0 : n_inc[CW-1:0];
        if (restart) flow_sum <= '0;
      end
      if (cmd.emit && open_reg) begin
        flow_sum <= flow_sum_next;
      end
    end
  end

  // item pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg    <= n_cur;
      open_reg <= 32'(n_cur) < 32'(cfg.open_len);
    end
    if (cmd.mul1) begin
      pos <= PROD_W'(cfg.lin_coef) * PROD_W'(n_reg);
      q1  <= PROD_W'(cfg.quad_coef) * PROD_W'(n_reg);
    end
    if (cmd.mul2) begin
      neg <= NEG_W'(q1) * NEG_W'(n_reg);
    end
    if (cmd.diff) begin
      dval <= $signed(DIFF_W'(pos) - DIFF_W'(neg));
    end
    if (cmd.deriv) begin
      d_reg <= d_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      open_phase      <= open_reg;
      flow_derivative <= open_reg ? d_reg : '0;
      if (open_reg) begin
        if (flow_sum_next > ACC_W'($signed({1'b0, {(OUT_W-1){1'b1}}}))) begin
          flow <= {1'b0, {(OUT_W-1){1'b1}}};
        end else if (flow_sum_next < ACC_W'($signed({1'b1, {(OUT_W-1){1'b0}}}))) begin
          flow <= {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          flow <= flow_sum_next[OUT_W-1:0];
        end
      end else begin
        if (flow_sum > ACC_W'($signed({1'b0, {(OUT_W-1){1'b1}}}))) begin
          flow <= {1'b0, {(OUT_W-1){1'b1}}};
        end else if (flow_sum < ACC_W'($signed({1'b1, {(OUT_W-1){1'b0}}}))) begin
          flow <= {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          flow <= flow_sum[OUT_W-1:0];
        end
      end
    end
  end

endmodule
